>>> rtl/hte_pkg.sv
// Shared types and constants for the homography transfer error scorer.
`default_nettype none
package hte_pkg;

   localparam int ENT_BITS   = 21;
   localparam int NUM_ROWS   = 3;
   localparam int ROW_BITS   = 63;
   localparam int THR_BITS   = 24;
   localparam int ERR_BITS   = 26;
   localparam int DIFF_BITS  = 14;
   localparam int FRAC_SHIFT = 13;
   localparam int CSR_IDX_BITS = 3;

   localparam logic signed [DIFF_BITS-1:0] DIFF_MAX = 14'sd4096;
   localparam logic signed [DIFF_BITS-1:0] DIFF_MIN = -14'sd4096;

   localparam logic [ROW_BITS-1:0] ROW0_RESET = 63'd1024;
   localparam logic [ROW_BITS-1:0] ROW1_RESET = 63'd2147483648;
   localparam logic [ROW_BITS-1:0] ROW2_RESET = 63'd2305843009213693952;
   localparam logic [THR_BITS-1:0] THR_RESET  = 24'd9188;

   typedef logic [NUM_ROWS-1:0][ROW_BITS-1:0] row_set_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FWD_ROW_0 = 3'd0,
      CSR_FWD_ROW_1 = 3'd1,
      CSR_FWD_ROW_2 = 3'd2,
      CSR_BWD_ROW_0 = 3'd3,
      CSR_BWD_ROW_1 = 3'd4,
      CSR_BWD_ROW_2 = 3'd5,
      CSR_THR       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic use_ny;
   } div_ctl_type;

endpackage
`default_nettype wire

>>> rtl/hte_if.sv
// Request and response channel interfaces for the transfer error scorer.
`default_nettype none
interface hte_req_if #(parameter int COORD_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x1;
   logic [COORD_BITS-1:0] y1;
   logic [COORD_BITS-1:0] x2;
   logic [COORD_BITS-1:0] y2;
   logic                  first;
   modport source (output valid, x1, y1, x2, y2, first, input ready);
   modport sink   (input valid, x1, y1, x2, y2, first, output ready);
endinterface

interface hte_rsp_if #(parameter int SCORE_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic                  inlier;
   logic                  forward_ok;
   logic [SCORE_BITS-1:0] score;
   modport source (output valid, inlier, forward_ok, score, input ready);
   modport sink   (input valid, inlier, forward_ok, score, output ready);
endinterface
`default_nettype wire

>>> rtl/hte_csr.sv
// Configuration registers: both homography matrices and the error threshold.
`default_nettype none
module hte_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [hte_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [hte_pkg::ROW_BITS-1:0]        csr_wdata,
   output hte_pkg::row_set_type                     fwd_rows,
   output hte_pkg::row_set_type                     bwd_rows,
   output logic [hte_pkg::THR_BITS-1:0]             thr
);
   import hte_pkg::*;

   row_set_type               fwd_ff, bwd_ff;
   logic [THR_BITS-1:0]       thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= {ROW2_RESET, ROW1_RESET, ROW0_RESET};
         bwd_ff <= {ROW2_RESET, ROW1_RESET, ROW0_RESET};
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FWD_ROW_0: fwd_ff[0] <= csr_wdata;
            CSR_FWD_ROW_1: fwd_ff[1] <= csr_wdata;
            CSR_FWD_ROW_2: fwd_ff[2] <= csr_wdata;
            CSR_BWD_ROW_0: bwd_ff[0] <= csr_wdata;
            CSR_BWD_ROW_1: bwd_ff[1] <= csr_wdata;
            CSR_BWD_ROW_2: bwd_ff[2] <= csr_wdata;
            CSR_THR:       thr_ff    <= csr_wdata[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign fwd_rows = fwd_ff;
   assign bwd_rows = bwd_ff;
   assign thr      = thr_ff;
endmodule
`default_nettype wire

>>> rtl/hte_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module hte_div #(
   parameter int NUM_W = 40,
   parameter int SHIFT = 13
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM_W-1:0]  num,
   input  wire logic signed [NUM_W-1:0]  den,
   output logic                          done,
   output logic signed [NUM_W+SHIFT:0]   quot
);
   localparam int DVD_W = NUM_W + SHIFT;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                       busy_ff, fix_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [DVD_W-1:0]           dvd_ff;
   logic [NUM_W:0]             rem_ff;
   logic [NUM_W-1:0]           den_ff;
   logic signed [DVD_W:0]      quot_ff;

   logic [NUM_W-1:0]           num_mag, den_mag;
   logic [NUM_W:0]             rem_sh, rem_in;
   logic                       ge;

   always_comb begin
      num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
      rem_sh  = {rem_ff[NUM_W-1:0], dvd_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fix_ff  <= 1'b0;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            fix_ff  <= 1'b1;
         end else if (fix_ff) begin
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num_mag, {SHIFT{1'b0}}};
         rem_ff <= '0;
         den_ff <= den_mag;
         neg_ff <= num[NUM_W-1] ^ den[NUM_W-1];
         cnt_ff <= CNT_W'(DVD_W);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (fix_ff) begin
         quot_ff <= neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> rtl/homography_transfer_error_score.sv
// Top level of the homography symmetric transfer error scorer.
// Each item is one matched point pair. Point 1 is projected through the
// forward homography and point 2 through the backward one, using a single
// shared signed multiplier (each product is registered and accumulated
// before another is formed) and a single shared restoring divider that
// produces one quotient bit per cycle. Per direction the sequencer works
// through the three matrix rows and the w check; unless w is zero it runs
// two divisions, each of one quotient step per bit of the COORD_BITS+37 bit
// dividend, a sign step and a handoff, squares each difference after its
// division and scores the direction. An item runs from the accepting step to
// the output step. The block takes a new item only while the sequencer is
// idle, but a finished result waits in the output register, so the next
// item may start before the previous result is taken. A projected w of zero
// fails that direction's test. The inlier flag follows only the backward
// test, the first flag clears the running score before the pair is scored,
// and the score saturates at its all-ones value. The user must write the
// configuration through csr_we, csr_index and csr_wdata only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module homography_transfer_error_score #(
   parameter int COORD_BITS = 16,
   parameter int SCORE_BITS = 40
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   hte_req_if.sink                                  req_ch,
   hte_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [hte_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [hte_pkg::ROW_BITS-1:0]        csr_wdata
);
   import hte_pkg::*;

   // Multiplier B operand must hold a signed coordinate or a clamped difference.
   localparam int BW    = (COORD_BITS + 1 > DIFF_BITS) ? COORD_BITS + 1 : DIFF_BITS;
   localparam int PW    = ENT_BITS + BW;
   localparam int SUM_W = COORD_BITS + 24;
   localparam int QW    = SUM_W + FRAC_SHIFT + 1;
   localparam int DW    = QW + 1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_ACC   = 9'b000000100,
      ST_CHK   = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_SQ    = 9'b000100000,
      ST_SQACC = 9'b001000000,
      ST_SCORE = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type                 st_ff, st_in;

   row_set_type               fwd_rows, bwd_rows;
   logic [THR_BITS-1:0]       thr;

   logic [COORD_BITS-1:0]     x1_ff, y1_ff, x2_ff, y2_ff;
   logic                      dir_ff, col_ff, part_ff, wnz_ff, fwd_ok_ff;
   logic [1:0]                row_ff;
   logic signed [SUM_W-1:0]   nx_ff, ny_ff, w_ff;
   logic signed [PW-1:0]      prod_ff;
   logic signed [DIFF_BITS-1:0] diff_ff;
   logic [ERR_BITS-1:0]       err_ff;
   logic [SCORE_BITS-1:0]     score_ff;

   logic                      rsp_valid_ff, rsp_inlier_ff, rsp_fwd_ff;
   logic [SCORE_BITS-1:0]     rsp_score_ff;

   logic [ROW_BITS-1:0]       row_sel;
   logic signed [ENT_BITS-1:0] ent_col, ent_off;
   logic [COORD_BITS-1:0]     px, py, rx, ry, pc, rc;
   logic signed [ENT_BITS-1:0] mul_a;
   logic signed [BW-1:0]      mul_b;
   logic signed [SUM_W-1:0]   acc_cur, acc_new;
   div_ctl_type               div_ctl;
   logic                      div_done;
   logic signed [QW-1:0]      quot;
   logic signed [DW-1:0]      dfull;
   logic signed [DIFF_BITS-1:0] dclamp;
   logic                      pass;
   logic [THR_BITS-1:0]       amt;
   logic [SCORE_BITS:0]       score_sum;
   logic [SCORE_BITS-1:0]     score_add;
   logic                      accept, out_free;

   hte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fwd_rows  (fwd_rows),
      .bwd_rows  (bwd_rows),
      .thr       (thr)
   );

   hte_div #(.NUM_W(SUM_W), .SHIFT(FRAC_SHIFT)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_ctl.start),
      .num   (div_ctl.use_ny ? ny_ff : nx_ff),
      .den   (w_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      // Forward maps point 1 onto point 2; backward maps point 2 onto point 1.
      px = dir_ff ? x2_ff : x1_ff;
      py = dir_ff ? y2_ff : y1_ff;
      rx = dir_ff ? x1_ff : x2_ff;
      ry = dir_ff ? y1_ff : y2_ff;
      pc = col_ff ? py : px;
      rc = part_ff ? ry : rx;

      row_sel = dir_ff ? bwd_rows[row_ff] : fwd_rows[row_ff];
      ent_col = signed'(row_sel[ENT_BITS*col_ff +: ENT_BITS]);
      ent_off = signed'(row_sel[2*ENT_BITS +: ENT_BITS]);

      if (st_ff == ST_SQ) begin
         mul_a = ENT_BITS'(diff_ff);
         mul_b = BW'(diff_ff);
      end else begin
         mul_a = ent_col;
         mul_b = signed'(BW'({1'b0, pc}));
      end

      case (row_ff)
         2'd0:    acc_cur = nx_ff;
         2'd1:    acc_cur = ny_ff;
         default: acc_cur = w_ff;
      endcase
      // The first column starts from the translation term scaled to Q.4 input.
      acc_new = (col_ff ? acc_cur : (SUM_W'(ent_off) <<< 4)) + SUM_W'(prod_ff);

      dfull = signed'(DW'({1'b0, rc})) - DW'(quot);
      if (dfull > DW'(DIFF_MAX))      dclamp = DIFF_MAX;
      else if (dfull < DW'(DIFF_MIN)) dclamp = DIFF_MIN;
      else                            dclamp = DIFF_BITS'(dfull);

      pass      = wnz_ff && (err_ff < ERR_BITS'(thr));
      amt       = thr - err_ff[THR_BITS-1:0];
      score_sum = {1'b0, score_ff} + (SCORE_BITS+1)'(amt);
      score_add = score_sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : score_sum[SCORE_BITS-1:0];

      div_ctl.start  = 1'b0;
      div_ctl.use_ny = 1'b0;
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:  if (accept) st_in = ST_MUL;
         ST_MUL:   st_in = ST_ACC;
         ST_ACC: begin
            if (col_ff && row_ff == 2'd2) st_in = ST_CHK;
            else                          st_in = ST_MUL;
         end
         ST_CHK: begin
            if (w_ff == '0) begin
               st_in = ST_SCORE;
            end else begin
               div_ctl.start = 1'b1;
               st_in = ST_DIV;
            end
         end
         ST_DIV:   if (div_done) st_in = ST_SQ;
         ST_SQ:    st_in = ST_SQACC;
         ST_SQACC: begin
            if (!part_ff) begin
               div_ctl.start  = 1'b1;
               div_ctl.use_ny = 1'b1;
               st_in = ST_DIV;
            end else begin
               st_in = ST_SCORE;
            end
         end
         ST_SCORE: st_in = dir_ff ? ST_OUT : ST_MUL;
         ST_OUT:   if (out_free) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         score_ff     <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)           rsp_valid_ff <= 1'b0;
         if (accept && req_ch.first)          score_ff <= '0;
         else if (st_ff == ST_SCORE && pass)  score_ff <= score_add;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               x1_ff   <= req_ch.x1;
               y1_ff   <= req_ch.y1;
               x2_ff   <= req_ch.x2;
               y2_ff   <= req_ch.y2;
               dir_ff  <= 1'b0;
               row_ff  <= 2'd0;
               col_ff  <= 1'b0;
            end
         end
         ST_MUL:   prod_ff <= PW'(mul_a) * PW'(mul_b);
         ST_ACC: begin
            case (row_ff)
               2'd0:    nx_ff <= acc_new;
               2'd1:    ny_ff <= acc_new;
               default: w_ff  <= acc_new;
            endcase
            col_ff <= ~col_ff;
            if (col_ff && row_ff != 2'd2) row_ff <= row_ff + 2'd1;
         end
         ST_CHK: begin
            wnz_ff  <= w_ff != '0;
            part_ff <= 1'b0;
         end
         ST_DIV:   if (div_done) diff_ff <= dclamp;
         ST_SQ:    prod_ff <= PW'(mul_a) * PW'(mul_b);
         ST_SQACC: begin
            err_ff  <= part_ff ? err_ff + ERR_BITS'(prod_ff) : ERR_BITS'(prod_ff);
            part_ff <= 1'b1;
         end
         ST_SCORE: begin
            if (!dir_ff) begin
               fwd_ok_ff <= pass;
               dir_ff    <= 1'b1;
               row_ff    <= 2'd0;
               col_ff    <= 1'b0;
            end else begin
               rsp_inlier_ff <= pass;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_fwd_ff   <= fwd_ok_ff;
               rsp_score_ff <= score_ff;
            end
         end
         default: ;
      endcase
   end

   assign req_ch.ready      = st_ff == ST_IDLE;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.forward_ok = rsp_fwd_ff;
   assign rsp_ch.score      = rsp_score_ff;

   // The inlier flag is captured in the scoring step and held until the slot frees.
   logic rsp_inl_out_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && out_free) rsp_inl_out_ff <= rsp_inlier_ff;
   end
   assign rsp_ch.inlier = rsp_inl_out_ff;
endmodule
`default_nettype wire

>>> rtl/hte_checker.sv
// Port-level checks for the transfer error scorer, bound to the top level.
`default_nettype none
module hte_checker #(
   parameter int SCORE_BITS = 40
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [SCORE_BITS-1:0] rsp_score
);
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("scorer not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("scorer took a second item while busy");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result shown in the cycle after its item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_score)))
      else $error("stalled result changed");
endmodule

bind homography_transfer_error_score hte_checker #(.SCORE_BITS(SCORE_BITS)) u_hte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_score (rsp_ch.score)
);
`default_nettype wire
